@@ rtl/idd_pkg.sv @@
// Package with shared types and constants for the integer divide to double block.
package idd_pkg;

  localparam int unsigned MagW   = 33;
  localparam int unsigned NormW  = 34;
  localparam int unsigned QBits  = 54;
  localparam int unsigned Stages = 6;
  localparam int unsigned BitsPerStage = QBits / Stages;
  localparam int unsigned ExpW   = 7;
  localparam int unsigned DataInW = 128;
  localparam int unsigned DataOutW = 64;

  localparam logic [63:0] QnanBits = 64'hFFF8000000000000;
  localparam logic [63:0] InfBits  = 64'h7FF0000000000000;
  localparam logic [10:0] ExpBias  = 11'd1023;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_INF    = 2'd2,
    KIND_NAN    = 2'd3
  } kind_e;

  // Item state that travels down the pipeline.
  typedef struct packed {
    logic              sign;
    kind_e             kind;
    logic signed [ExpW-1:0] expo;
    logic [NormW-1:0]  den;
    logic [NormW:0]    rem;
    logic [QBits-1:0]  quo;
    logic [63:0]       mask;
  } item_t;

  function automatic logic [5:0] top_bit(input logic [MagW-1:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < MagW; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

@@ rtl/idd_front.sv @@
// Front stage: magnitudes, special-case detection and operand normalization.
module idd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        dividend_i,
  input  logic [31:0]        divisor_i,
  input  logic [63:0]        mask_i,
  output logic               valid_o,
  output idd_pkg::item_t     item_o
);

  logic [idd_pkg::MagW-1:0] ua, ub;
  logic [5:0] ea, eb;
  logic [idd_pkg::NormW-1:0] num, den;
  logic signed [idd_pkg::ExpW-1:0] e;
  idd_pkg::item_t item_d, item_q;
  logic valid_q;

  always_comb begin
    ua = dividend_i[31] ? idd_pkg::MagW'(33'h100000000 - {1'b0, dividend_i})
                        : {1'b0, dividend_i};
    ub = divisor_i[31] ? idd_pkg::MagW'(33'h100000000 - {1'b0, divisor_i})
                       : {1'b0, divisor_i};
    ea = idd_pkg::top_bit(ua);
    eb = idd_pkg::top_bit(ub);
    num = idd_pkg::NormW'({1'b0, ua} << (6'd32 - ea));
    den = idd_pkg::NormW'({1'b0, ub} << (6'd32 - eb));
    e = idd_pkg::ExpW'($signed({1'b0, ea}) - $signed({1'b0, eb}));
    item_d = '0;
    item_d.mask = mask_i;
    item_d.den = den;
    item_d.sign = dividend_i[31] ^ divisor_i[31];
    if (ua == '0 && ub == '0) begin
      item_d.kind = idd_pkg::KIND_NAN;
    end else if (ua == '0) begin
      item_d.kind = idd_pkg::KIND_ZERO;
      item_d.sign = divisor_i[31];
    end else if (ub == '0) begin
      item_d.kind = idd_pkg::KIND_INF;
      item_d.sign = dividend_i[31];
    end else begin
      item_d.kind = idd_pkg::KIND_NORMAL;
    end
    if (num < den) begin
      item_d.rem = {num, 1'b0};
      item_d.expo = e - idd_pkg::ExpW'(1);
    end else begin
      item_d.rem = {1'b0, num};
      item_d.expo = e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/idd_div_stage.sv @@
// One restoring-division stage that retires a fixed number of quotient bits.
module idd_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  idd_pkg::item_t item_i,
  output logic           valid_o,
  output idd_pkg::item_t item_o
);

  idd_pkg::item_t item_d, item_q;
  logic valid_q;

  always_comb begin
    item_d = item_i;
    for (int i = 0; i < idd_pkg::BitsPerStage; i++) begin
      item_d.quo = item_d.quo << 1;
      if (item_d.rem >= {1'b0, item_d.den}) begin
        item_d.rem = item_d.rem - {1'b0, item_d.den};
        item_d.quo[0] = 1'b1;
      end
      item_d.rem = item_d.rem << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/idd_round.sv @@
// Rounding, packing into double format and mask application.
module idd_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  idd_pkg::item_t item_i,
  output logic           valid_o,
  output logic [63:0]    bits_o
);

  logic [53:0] mant;
  logic signed [idd_pkg::ExpW-1:0] e;
  logic [10:0] bexp;
  logic [63:0] val, bits_d, bits_q;
  logic valid_q;

  always_comb begin
    mant = {1'b0, item_i.quo[idd_pkg::QBits-1:1]};
    e = item_i.expo;
    if (item_i.quo[0] && (item_i.rem != '0 || mant[0])) mant = mant + 54'd1;
    if (mant[53]) begin
      mant = mant >> 1;
      e = e + idd_pkg::ExpW'(1);
    end
    bexp = idd_pkg::ExpBias + 11'($signed(e));
    unique case (item_i.kind)
      idd_pkg::KIND_NAN:  val = idd_pkg::QnanBits;
      idd_pkg::KIND_ZERO: val = {item_i.sign, 63'd0};
      idd_pkg::KIND_INF:  val = idd_pkg::InfBits | {item_i.sign, 63'd0};
      default:            val = {item_i.sign, bexp, mant[51:0]};
    endcase
    bits_d = val ^ item_i.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) bits_q <= bits_d;
  end

  assign valid_o = valid_q;
  assign bits_o  = bits_q;

endmodule

@@ rtl/int_divide_to_double_xor.sv @@
// Top level of the pipelined integer divide to masked IEEE double block.
//
//  Channel | Direction | Payload
//  s_axis  | in        | tdata: dividend[31:0], divisor[63:32], xor_mask[127:64]
//  m_axis  | out       | tdata: result_bits[63:0]
//
// The pipeline holds a normalization stage, six division stages of nine
// quotient bits each, and a rounding stage. One beat is accepted every cycle
// while the pipeline advances. The whole pipeline advances together whenever
// the output register is empty or being drained, so a stall freezes every
// stage and loses nothing. Reset clears only the valid bits.
module int_divide_to_double_xor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // dividend[31:0], divisor[63:32], xor_mask[127:64]
  input  logic [idd_pkg::DataInW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // result_bits[63:0]
  output logic [idd_pkg::DataOutW-1:0] m_axis_tdata
);

  logic en;
  logic           v [idd_pkg::Stages+1];
  idd_pkg::item_t it [idd_pkg::Stages+1];

  // The pipe moves when the last stage holds nothing or is being taken.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  idd_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid),
    .dividend_i(s_axis_tdata[31:0]),
    .divisor_i(s_axis_tdata[63:32]),
    .mask_i(s_axis_tdata[127:64]),
    .valid_o(v[0]), .item_o(it[0])
  );

  for (genvar g = 0; g < idd_pkg::Stages; g++) begin : g_div
    idd_div_stage u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v[g]), .item_i(it[g]),
      .valid_o(v[g+1]), .item_o(it[g+1])
    );
  end

  idd_round u_round (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v[idd_pkg::Stages]), .item_i(it[idd_pkg::Stages]),
    .valid_o(m_axis_tvalid), .bits_o(m_axis_tdata)
  );

endmodule

@@ tb/int_divide_to_double_xor_checker.sv @@
// Checker that predicts masked double quotients and compares them with the output stream.
`timescale 1ns / 1ps

module int_divide_to_double_xor_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [idd_pkg::DataInW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [idd_pkg::DataOutW-1:0] m_axis_tdata,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);

  logic [63:0] quotient_q[$];

  // Exact long division of the operand magnitudes, rounded to nearest even.
  function automatic logic [63:0] quotient_bits(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] ma, mb;
    logic [63:0] num, den, q, r, mant;
    logic        neg_a, neg_b, rnd, sticky;
    int          ea, eb, e;
    neg_a = a[31];
    neg_b = b[31];
    ma = neg_a ? (33'h100000000 - {1'b0, a}) : {1'b0, a};
    mb = neg_b ? (33'h100000000 - {1'b0, b}) : {1'b0, b};
    if (ma == 0 && mb == 0) return idd_pkg::QnanBits;
    if (ma == 0) return neg_b ? 64'h8000000000000000 : 64'h0;
    if (mb == 0) return idd_pkg::InfBits | {neg_a, 63'h0};
    ea = 0;
    eb = 0;
    for (int i = 0; i < 33; i++) begin
      if (ma[i]) ea = i;
      if (mb[i]) eb = i;
    end
    num = 64'(ma) << (32 - ea);
    den = 64'(mb) << (32 - eb);
    e = ea - eb;
    if (num < den) begin
      num = num << 1;
      e = e - 1;
    end
    q = 0;
    r = num;
    for (int i = 0; i < 54; i++) begin
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
      r = r << 1;
    end
    rnd = q[0];
    sticky = (r != 0);
    mant = q >> 1;
    if (rnd && (sticky || mant[0])) mant = mant + 1;
    if (mant[53]) begin
      mant = mant >> 1;
      e = e + 1;
    end
    return {neg_a ^ neg_b, 11'(e + 1023), mant[51:0]};
  endfunction

  assign pending_o = quotient_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        quotient_q.push_back(quotient_bits(s_axis_tdata[31:0], s_axis_tdata[63:32])
                             ^ s_axis_tdata[127:64]);
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o <= checked_o + 1;
        if (quotient_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = quotient_q.pop_front();
          if (want !== m_axis_tdata) begin
            $display("%0t: result_bits expected %h actual %h", $time, want, m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/int_divide_to_double_xor_tb.sv @@
// Testbench top: drives division beats with random idling and gives the verdict.
`timescale 1ns / 1ps

module int_divide_to_double_xor_tb;

  localparam int RandomBeats = 800;
  localparam int CycleLimit  = 200000;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  // dividend[31:0], divisor[63:32], xor_mask[127:64]
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  // result_bits[63:0]
  logic [63:0]  m_axis_tdata;
  int           fail_count, pending, checked, cycles;
  int           send_idle, recv_stall;

  int_divide_to_double_xor u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  int_divide_to_double_xor_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: the slowest run is well under this many cycles.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("int_divide_to_double_xor_tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls at the percentage of the current phase, redrawn each cycle.
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall);

  // Operand mix: edge values and small numbers are common so that exact
  // quotients, ties and zero cases turn up among the wide random ones.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'(int'($urandom_range(6)) - 3);
      3: return 32'(1) << $urandom_range(31);
      4: return 32'(int'($urandom_range(2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  // Presents one beat, idles first as often as the phase asks, then holds
  // it until accepted.
  task automatic send_beat(input logic [31:0] a, input logic [31:0] b, input logic [63:0] m);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {m, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] edge_ops[7];
    edge_ops = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h3, 32'hFFFFFFF9};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: each edge operand over itself and the next two in the list
    // covers zero over zero, signed zeros, both infinities and the most negative
    // magnitude; the masks are all zeros and all ones.
    foreach (edge_ops[i]) begin
      for (int j = 0; j < 3; j++)
        send_beat(edge_ops[i], edge_ops[(i + j) % 7], j[0] ? 64'hFFFFFFFFFFFFFFFF : 64'h0);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      for (int n = 0; n < RandomBeats / 4; n++)
        send_beat(pick_operand(), pick_operand(), {$urandom(), $urandom()});
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker record the last accepted beat before draining.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d result beats: edge operands, zero and infinite quotients,", checked);
    $display("random operands and masks under four idling phases.");
    if (fail_count == 0) begin
      $display("int_divide_to_double_xor_tb: done, clean");
    end else begin
      $display("int_divide_to_double_xor_tb: done, errors");
    end
    $finish;
  end

endmodule
